/* rtl/core/max_priority_queue_macros.svh */
// assertion macros for the max priority queue
`ifndef MAX_PRIORITY_QUEUE_MACROS_SVH
`define MAX_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MPQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("max_priority_queue: same-cycle check failed");

// next-cycle implication, checked out of reset
`define MPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("max_priority_queue: next-cycle check failed");

`endif

/* rtl/core/mpq_pkg.sv */
// ----------------------------------------------------------------------------
// mpq_pkg
// shared types and constants of the max priority queue
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int MPQ_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 5;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_action action;
        t_data   value;
    } t_in_beat;

    typedef struct packed {
        t_data            removed_value;
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_out_beat;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic  valid;
        logic  gt;
        t_data value;
    } t_cell_link;

endpackage

/* rtl/core/mpq_stream_if.sv */
// ----------------------------------------------------------------------------
// mpq_stream_if
// valid/ready channel carrying one beat of payload type t
// ----------------------------------------------------------------------------
interface mpq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/max_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_priority_queue
// bounded max priority queue kept as a sorted chain of cells, head = greatest
// ----------------------------------------------------------------------------
// channel  dir  payload                                  role
// i_in     in   action, value                            insert / remove beat
// o_out    out  removed_value, status, occupancy         one result per beat
//
// one beat per cycle unless o_out stalls; each beat is applied to the chain as taken
// results sit in an output register; a new beat is taken when it is empty or read
// a stalled output holds i_in off; no other stall source
// synchronous active-low reset empties the chain at once, no clearing pass
// ----------------------------------------------------------------------------
`include "max_priority_queue_macros.svh"

module max_priority_queue import mpq_pkg::*; #(
    parameter int CAPACITY = MPQ_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mpq_stream_if.sink           i_in,
    mpq_stream_if.source         o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_beat     r_out;
    t_out_beat     n_out;
    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    t_cell_ctrl    w_ctrl;
    t_cell_link    w_link [CAPACITY];

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);

    assign w_ctrl.ins = w_accept && (i_in.data.action == ACT_INSERT) && !w_full;
    assign w_ctrl.rem = w_accept && (i_in.data.action == ACT_REMOVE) && !w_empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;
        if (g == 0) begin : g_head
            assign w_left = '{valid: 1'b1, gt: 1'b0, value: '0};
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '{valid: 1'b0, gt: 1'b0, value: '0};
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end
        mpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_new   (i_in.data.value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );
    end

    always_comb begin
        n_count             = r_count;
        n_out.removed_value = '0;
        n_out.status        = ST_OK;
        if (i_in.data.action == ACT_INSERT) begin
            if (w_full) begin
                n_out.status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_out.status = ST_EMPTY;
            end else begin
                n_out.removed_value = w_link[0].value;
                n_count             = r_count - 1'b1;
            end
        end
        n_out.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `MPQ_ASSERT_IMPL(a_count_range, 1'b1, r_count <= CW'(CAPACITY))
    `MPQ_ASSERT_IMPL(a_head_valid, 1'b1, (r_count != '0) == w_link[0].valid)
    `MPQ_ASSERT_NEXT(a_remove_count, w_ctrl.rem, r_count == $past(r_count) - 1'b1)

endmodule

/* rtl/core/mpq_cell.sv */
// ----------------------------------------------------------------------------
// mpq_cell
// one slot of the sorted chain; shifts right on insert, left on remove
// ----------------------------------------------------------------------------
module mpq_cell import mpq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_data      i_new,
    input  t_cell_link i_left,
    input  t_cell_link i_right,
    output t_cell_link o_link
);

    logic  r_valid;
    logic  n_valid;
    t_data r_value;
    t_data n_value;
    logic  w_gt;

    assign w_gt   = !r_valid || (i_new > r_value);
    assign o_link = '{valid: r_valid, gt: w_gt, value: r_value};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.rem) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end else if (i_ctrl.ins && w_gt) begin
            if (i_left.gt) begin
                // make room: take the left neighbor
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else begin
                n_valid = 1'b1;
                n_value = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

/* bench/tb_max_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_priority_queue
// drives insert and remove beats into the queue under random bursts and
// output stalls, predicts each result from a plain list of stored values
// and checks every result beat field by field
// ----------------------------------------------------------------------------
module tb_max_priority_queue;
    import mpq_pkg::*;

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;

    localparam t_data VAL_MAX = 32'sh7FFF_FFFF;
    localparam t_data VAL_MIN = 32'sh8000_0000;

    logic i_clk;
    logic i_rst_n;

    mpq_stream_if #(.T(t_in_beat))  in_if ();
    mpq_stream_if #(.T(t_out_beat)) out_if ();

    max_priority_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_data     stored_values[$];
    t_out_beat pending_results[$];
    int        error_count;
    int        idle_cycles;
    int        burst_left;
    bit        hold_off_req;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out_beat apply_queue_op(t_action act, t_data val);
        t_out_beat res;
        int        best;
        res        = '0;
        res.status = ST_OK;
        if (act == ACT_INSERT) begin
            if (stored_values.size() >= MPQ_CAPACITY)
                res.status = ST_FULL;
            else
                stored_values.push_back(val);
        end else if (stored_values.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            best = 0;
            for (int i = 1; i < stored_values.size(); i++)
                if (stored_values[i] > stored_values[best])
                    best = i;
            res.removed_value = stored_values[best];
            stored_values.delete(best);
        end
        res.occupancy = OCC_W'(stored_values.size());
        return res;
    endfunction

    function automatic t_data pick_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3:    return t_data'($urandom_range(0, 15)) - 32'sd8;
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic send_beat(input t_action act, input t_data val);
        @(negedge i_clk);
        in_if.valid       <= 1'b1;
        in_if.data.action <= act;
        in_if.data.value  <= val;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pending_results.push_back(apply_queue_op(act, val));
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
    endtask

    // bursts of random length, most of them preceded by a random gap
    task automatic burst_gap();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end
        burst_left--;
    endtask

    task automatic wait_all_results();
        idle_sender(1);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_beat(ACT_REMOVE, t_data'($urandom));
        send_beat(ACT_INSERT, VAL_MIN);
        send_beat(ACT_INSERT, VAL_MAX);
        send_beat(ACT_INSERT, 32'sd0);
        send_beat(ACT_INSERT, -32'sd1);
        send_beat(ACT_INSERT, VAL_MAX);
        repeat (3) send_beat(ACT_REMOVE, t_data'($urandom));
        for (int i = 0; i < MPQ_CAPACITY - 2; i++)
            send_beat(ACT_INSERT, (i % 2) ? 32'sh5555_5555 : (32'shAAAA_AAAA ^ i));
        send_beat(ACT_INSERT, 32'sd1);
        send_beat(ACT_REMOVE, t_data'($urandom));
    endtask

    task automatic test_random_traffic(input int count);
        int ins_pct;
        ins_pct = 50;
        for (int n = 0; n < count; n++) begin
            // shift the mix now and then so the queue fills and drains
            if (n % 60 == 0) begin
                case ($urandom_range(0, 3))
                    0:       ins_pct = 20;
                    1:       ins_pct = 50;
                    2:       ins_pct = 80;
                    default: ins_pct = 95;
                endcase
            end
            burst_gap();
            if ($urandom_range(1, 100) <= ins_pct)
                send_beat(ACT_INSERT, pick_value());
            else
                send_beat(ACT_REMOVE, t_data'($urandom));
        end
    endtask

    task automatic test_output_stall();
        hold_off_req = 1'b1;
        for (int n = 0; n < 40; n++)
            send_beat(($urandom_range(0, 2) != 0) ? ACT_INSERT : ACT_REMOVE, pick_value());
    endtask

    task automatic test_drain_pause();
        wait_all_results();
        for (int n = 0; n < 60; n++) begin
            burst_gap();
            send_beat(($urandom_range(0, 1) != 0) ? ACT_INSERT : ACT_REMOVE, pick_value());
        end
    endtask

    // receiver stall pattern
    initial begin
        logic [7:0] stall_mask;
        int         phase;
        int         hold_left;
        bit         always_ready;
        out_if.ready = 1'b0;
        stall_mask   = '1;
        phase        = 0;
        hold_left    = 0;
        always_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (phase % 32 == 0) begin
                always_ready = ($urandom_range(0, 3) == 0);
                stall_mask   = 8'($urandom);
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= always_ready | stall_mask[phase % 8];
            end
            phase++;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, out_if.data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_if.data.removed_value !== want.removed_value) begin
                    $display("%0t: removed_value expected %0d actual %0d",
                             $time, want.removed_value, out_if.data.removed_value);
                    error_count++;
                end
                if (out_if.data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_if.data.status);
                    error_count++;
                end
                if (out_if.data.occupancy !== want.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, out_if.data.occupancy);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        error_count  = 0;
        idle_cycles  = 0;
        burst_left   = 0;
        hold_off_req = 1'b0;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(1500);
        test_output_stall();
        test_drain_pause();

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
